### design/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Checked on every clock edge outside reset.
`define LPBE_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LPBE_ASSERT_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LPBE_ASSERT(name, clk, rst, prop, msg)
`define LPBE_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

### design/lpbe_pkg.sv
`default_nettype none

package lpbe_pkg;

   // Fixed field widths
   localparam int BTN_W      = 8;
   localparam int TMO_W      = 16;
   localparam int THR_W      = 16;
   localparam int CSR_DATA_W = 16;
   localparam int CSR_ADDR_W = 2;

   // Register reset values
   localparam logic [TMO_W-1:0] TIMEOUT_RST = 16'd1000;
   localparam logic [BTN_W-1:0] TARGET_RST  = 8'd3;
   localparam logic [THR_W-1:0] THRESH_RST  = 16'd20;

   // Button that starts a hold and is replayed on cancel
   localparam logic [BTN_W-1:0] HOLD_BUTTON = 8'd1;

   typedef enum logic [1:0] {
      OP_BUTTON = 2'd0,
      OP_ABS    = 2'd1,
      OP_REL    = 2'd2,
      OP_TICK   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_IDLE      = 2'd0,
      MODE_PENDING   = 2'd1,
      MODE_EMULATING = 2'd2
   } mode_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_ENABLE    = 2'd0,
      CSR_TIMEOUT   = 2'd1,
      CSR_TARGET    = 2'd2,
      CSR_THRESHOLD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             enable;
      logic [TMO_W-1:0] timeout_ms;
      logic [BTN_W-1:0] target_button;
      logic [THR_W-1:0] move_threshold;
   } cfg_type;

endpackage

`default_nettype wire

### design/long_press_button_emulator_unit.sv
// Channel  Dir  Ports                   Contents
// req      in   req_tvalid/tready/tdata  button, motion or tick word; tuser = operation
// rsp      out  rsp_tvalid/tready/tdata  one result word per request word
// csr      in   csr_we/addr/wdata        enable, timeout_ms, target_button, move_threshold
//
// One word per cycle sustained while rsp is ready; a word reaches rsp through
// the input register, then hold logic into the result register.
// Every request word gives exactly one result word.
// Reset is synchronous and clears the hold state, valid flags and CSRs to defaults.
// A stalled rsp holds its word; req keeps accepting until both registers are full.
`default_nettype none

module long_press_button_emulator_unit #(
   parameter int COORD_WIDTH = 16,
   parameter int TIMER_WIDTH = 16
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // button_number, press, x_present, y_present, coord_x, coord_y, zero pad
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [((11+2*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // operation
   input  wire logic [1:0]                       req_tuser,
   // swallowed, emit_valid, emit_button, emit_press, emit_absolute, emit_x,
   // emit_y, zero pad
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic [((12+2*COORD_WIDTH+7)/8)*8-1:0] rsp_tdata,
   input  wire logic                             csr_we,
   input  wire logic [lpbe_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [lpbe_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   localparam int IN_W  = ((11 + 2 * COORD_WIDTH + 7) / 8) * 8;
   localparam int OUT_W = ((12 + 2 * COORD_WIDTH + 7) / 8) * 8;

   lpbe_pkg::cfg_type cfg;
   logic              space;
   logic              fire;
   logic [IN_W-1:0]   item_data;
   logic [1:0]        item_op;
   logic [OUT_W-1:0]  res_data;

   lpbe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   lpbe_in_reg #(
      .DATA_W (IN_W)
   ) u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .space      (space),
      .fire       (fire),
      .item_data  (item_data),
      .item_op    (item_op)
   );

   lpbe_hold_ctrl #(
      .COORD_WIDTH (COORD_WIDTH),
      .TIMER_WIDTH (TIMER_WIDTH),
      .IN_W        (IN_W),
      .OUT_W       (OUT_W)
   ) u_hold_ctrl (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .item_data (item_data),
      .item_op   (item_op),
      .cfg       (cfg),
      .res_data  (res_data)
   );

   lpbe_out_reg #(
      .DATA_W (OUT_W)
   ) u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .res_data   (res_data),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .space      (space)
   );

endmodule

`default_nettype wire

### design/lpbe_csr.sv
`default_nettype none

module lpbe_csr (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             csr_we,
   input  wire logic [lpbe_pkg::CSR_ADDR_W-1:0]  csr_addr,
   input  wire logic [lpbe_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output lpbe_pkg::cfg_type                     cfg
);

   lpbe_pkg::cfg_type cfg_ff;

   // Register file, one write per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable         <= 1'b0;
         cfg_ff.timeout_ms     <= lpbe_pkg::TIMEOUT_RST;
         cfg_ff.target_button  <= lpbe_pkg::TARGET_RST;
         cfg_ff.move_threshold <= lpbe_pkg::THRESH_RST;
      end else if (csr_we) begin
         unique case (lpbe_pkg::csr_index_type'(csr_addr))
            lpbe_pkg::CSR_ENABLE: begin
               cfg_ff.enable <= csr_wdata[0];
            end
            lpbe_pkg::CSR_TIMEOUT: begin
               cfg_ff.timeout_ms <= csr_wdata[lpbe_pkg::TMO_W-1:0];
            end
            lpbe_pkg::CSR_TARGET: begin
               cfg_ff.target_button <= csr_wdata[lpbe_pkg::BTN_W-1:0];
            end
            lpbe_pkg::CSR_THRESHOLD: begin
               cfg_ff.move_threshold <= csr_wdata[lpbe_pkg::THR_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

### design/lpbe_in_reg.sv
`default_nettype none

module lpbe_in_reg #(
   parameter int DATA_W = 48
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire logic [DATA_W-1:0] req_tdata,
   input  wire logic [1:0]        req_tuser,
   input  wire logic              space,
   output logic                   fire,
   output logic [DATA_W-1:0]      item_data,
   output logic [1:0]             item_op
);

   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] data_ff;
   logic [1:0]        op_ff;
   logic              accept;

   // Held word moves on whenever the result side has room
   assign fire       = valid_ff & space;
   assign req_tready = ~valid_ff | space;
   assign accept     = req_tvalid & req_tready;
   assign valid_in   = accept | (valid_ff & ~space);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff <= req_tdata;
         op_ff   <= req_tuser;
      end
   end

   assign item_data = data_ff;
   assign item_op   = op_ff;

endmodule

`default_nettype wire

### design/lpbe_hold_ctrl.sv
`default_nettype none

`include "assert_macros.svh"

module lpbe_hold_ctrl #(
   parameter int COORD_WIDTH = 16,
   parameter int TIMER_WIDTH = 16,
   parameter int IN_W        = 48,
   parameter int OUT_W       = 48
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire logic [IN_W-1:0] item_data,
   input  wire logic [1:0]      item_op,
   input  wire lpbe_pkg::cfg_type cfg,
   output logic [OUT_W-1:0]     res_data
);

   localparam int C     = COORD_WIDTH;
   localparam int BW    = lpbe_pkg::BTN_W;
   localparam int CMPW  = (C + 2 > lpbe_pkg::THR_W) ? C + 2 : lpbe_pkg::THR_W;
   localparam int TX    = (TIMER_WIDTH > lpbe_pkg::TMO_W) ? TIMER_WIDTH : lpbe_pkg::TMO_W;
   localparam logic [TX-1:0] TMASK = TX'((64'd1 << TIMER_WIDTH) - 64'd1);

   // Input word fields
   logic [BW-1:0]         btn;
   logic                  pr;
   logic                  xp;
   logic                  yp;
   logic [C-1:0]          cx;
   logic [C-1:0]          cy;
   lpbe_pkg::op_type      op;

   assign btn = item_data[BW-1:0];
   assign pr  = item_data[BW];
   assign xp  = item_data[BW+1];
   assign yp  = item_data[BW+2];
   assign cx  = item_data[BW+3 +: C];
   assign cy  = item_data[BW+3+C +: C];
   assign op  = lpbe_pkg::op_type'(item_op);

   // Hold state
   lpbe_pkg::mode_type    mode_ff, mode_in;
   logic [C-1:0]          start_x_ff, start_x_in;
   logic [C-1:0]          start_y_ff, start_y_in;
   logic [C+1:0]          accum_dx_ff, accum_dx_in;
   logic [C+1:0]          accum_dy_ff, accum_dy_in;
   logic                  abs_seen_ff, abs_seen_in;
   logic [TIMER_WIDTH-1:0] elapsed_ff, elapsed_in;

   // Distance from the start position
   logic [C:0]            diff_x, diff_y;
   logic [C:0]            mag_x, mag_y;
   logic                  far_x, far_y;
   logic [CMPW-1:0]       thr_ext;

   assign thr_ext = CMPW'(cfg.move_threshold);
   assign diff_x  = {cx[C-1], cx} - {start_x_ff[C-1], start_x_ff};
   assign diff_y  = {cy[C-1], cy} - {start_y_ff[C-1], start_y_ff};
   assign mag_x   = diff_x[C] ? (~diff_x + 1'b1) : diff_x;
   assign mag_y   = diff_y[C] ? (~diff_y + 1'b1) : diff_y;
   assign far_x   = CMPW'(mag_x) > thr_ext;
   assign far_y   = CMPW'(mag_y) > thr_ext;

   // Saturating relative accumulation
   logic [C+2:0]          sum_x, sum_y;
   logic [C+1:0]          acc_x, acc_y;
   logic [C+1:0]          amag_x, amag_y;
   logic                  far_ax, far_ay;
   localparam logic [C+1:0] ACC_MAX = {1'b0, {(C+1){1'b1}}};
   localparam logic [C+1:0] ACC_MIN = {1'b1, {(C+1){1'b0}}};

   assign sum_x  = {accum_dx_ff[C+1], accum_dx_ff} + {{3{cx[C-1]}}, cx};
   assign sum_y  = {accum_dy_ff[C+1], accum_dy_ff} + {{3{cy[C-1]}}, cy};
   assign acc_x  = (sum_x[C+2] != sum_x[C+1]) ? (sum_x[C+2] ? ACC_MIN : ACC_MAX)
                                              : sum_x[C+1:0];
   assign acc_y  = (sum_y[C+2] != sum_y[C+1]) ? (sum_y[C+2] ? ACC_MIN : ACC_MAX)
                                              : sum_y[C+1:0];
   assign amag_x = acc_x[C+1] ? (~acc_x + 1'b1) : acc_x;
   assign amag_y = acc_y[C+1] ? (~acc_y + 1'b1) : acc_y;
   assign far_ax = CMPW'(amag_x) > thr_ext;
   assign far_ay = CMPW'(amag_y) > thr_ext;

   // Hold timer
   logic [TIMER_WIDTH-1:0] elapsed_inc;
   logic [TX-1:0]          tmo;
   logic                   timed_out;

   assign elapsed_inc = (&elapsed_ff) ? elapsed_ff : elapsed_ff + 1'b1;
   assign tmo         = TX'(cfg.timeout_ms) & TMASK;
   assign timed_out   = TX'(elapsed_inc) >= tmo;

   // Result fields
   logic                  swallow;
   logic                  emit_v;
   logic [BW-1:0]         emit_btn;
   logic                  emit_pr;
   logic                  emit_abs_src;
   logic                  emit_abs;
   logic [C-1:0]          emit_x;
   logic [C-1:0]          emit_y;
   logic                  cancel;

   // Next state and result for one word
   always_comb begin
      mode_in      = mode_ff;
      start_x_in   = start_x_ff;
      start_y_in   = start_y_ff;
      accum_dx_in  = accum_dx_ff;
      accum_dy_in  = accum_dy_ff;
      abs_seen_in  = abs_seen_ff;
      elapsed_in   = elapsed_ff;
      swallow      = 1'b0;
      emit_v       = 1'b0;
      emit_btn     = '0;
      emit_pr      = 1'b0;
      emit_abs_src = abs_seen_ff;
      cancel       = 1'b0;

      unique case (op)
         lpbe_pkg::OP_BUTTON: begin
            if (cfg.enable) begin
               if (btn != lpbe_pkg::HOLD_BUTTON || !pr) begin
                  if (mode_ff == lpbe_pkg::MODE_PENDING) begin
                     // replay the swallowed press
                     emit_v   = 1'b1;
                     emit_btn = lpbe_pkg::HOLD_BUTTON;
                     emit_pr  = 1'b1;
                     cancel   = 1'b1;
                  end else if (mode_ff == lpbe_pkg::MODE_EMULATING) begin
                     emit_v   = 1'b1;
                     emit_btn = cfg.target_button;
                     emit_pr  = 1'b0;
                     cancel   = 1'b1;
                     swallow  = (btn == lpbe_pkg::HOLD_BUTTON);
                  end
               end else if (mode_ff == lpbe_pkg::MODE_IDLE) begin
                  mode_in    = lpbe_pkg::MODE_PENDING;
                  elapsed_in = '0;
                  swallow    = 1'b1;
               end
            end
         end
         lpbe_pkg::OP_ABS: begin
            if (mode_ff != lpbe_pkg::MODE_PENDING) begin
               if (xp) start_x_in = cx;
               if (yp) start_y_in = cy;
            end else begin
               abs_seen_in  = 1'b1;
               emit_abs_src = 1'b1;
               if ((xp && far_x) || (yp && far_y)) begin
                  emit_v   = 1'b1;
                  emit_btn = lpbe_pkg::HOLD_BUTTON;
                  emit_pr  = 1'b1;
                  cancel   = 1'b1;
               end
            end
         end
         lpbe_pkg::OP_REL: begin
            if (mode_ff == lpbe_pkg::MODE_PENDING) begin
               accum_dx_in = acc_x;
               accum_dy_in = acc_y;
               if (far_ax || far_ay) begin
                  emit_v   = 1'b1;
                  emit_btn = lpbe_pkg::HOLD_BUTTON;
                  emit_pr  = 1'b1;
                  cancel   = 1'b1;
               end
            end
         end
         lpbe_pkg::OP_TICK: begin
            if (mode_ff == lpbe_pkg::MODE_PENDING && tmo != '0) begin
               elapsed_in = elapsed_inc;
               if (timed_out) begin
                  mode_in  = lpbe_pkg::MODE_EMULATING;
                  emit_v   = 1'b1;
                  emit_btn = cfg.target_button;
                  emit_pr  = 1'b1;
               end
            end
         end
         default: begin
         end
      endcase

      // Leaving a hold clears its bookkeeping
      if (cancel) begin
         mode_in     = lpbe_pkg::MODE_IDLE;
         accum_dx_in = '0;
         accum_dy_in = '0;
         abs_seen_in = 1'b0;
         elapsed_in  = '0;
      end
   end

   assign emit_abs = emit_v & emit_abs_src;
   assign emit_x   = emit_abs ? start_x_ff : '0;
   assign emit_y   = emit_abs ? start_y_ff : '0;

   // Packed result: swallowed, emit_valid, button, press, absolute, x, y
   assign res_data = OUT_W'({emit_y, emit_x, emit_abs, emit_pr, emit_btn, emit_v, swallow});

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= lpbe_pkg::MODE_IDLE;
         start_x_ff  <= '0;
         start_y_ff  <= '0;
         accum_dx_ff <= '0;
         accum_dy_ff <= '0;
         abs_seen_ff <= 1'b0;
         elapsed_ff  <= '0;
      end else if (fire) begin
         mode_ff     <= mode_in;
         start_x_ff  <= start_x_in;
         start_y_ff  <= start_y_in;
         accum_dx_ff <= accum_dx_in;
         accum_dy_ff <= accum_dy_in;
         abs_seen_ff <= abs_seen_in;
         elapsed_ff  <= elapsed_in;
      end
   end

   // Idle means every hold counter has been cleared
   `LPBE_ASSERT(a_idle_clean, clock, reset,
      mode_ff == lpbe_pkg::MODE_IDLE |-> (elapsed_ff == '0 && !abs_seen_ff &&
      accum_dx_ff == '0 && accum_dy_ff == '0), "idle with stale hold state")
   // Nothing is synthesized out of idle
   `LPBE_ASSERT(a_idle_quiet, clock, reset,
      fire && mode_ff == lpbe_pkg::MODE_IDLE |-> !emit_v, "event emitted while idle")
   // Only button words are ever swallowed
   `LPBE_ASSERT(a_swallow_btn, clock, reset,
      fire && swallow |-> op == lpbe_pkg::OP_BUTTON, "non-button word swallowed")
   // An event during emulation is always the target release
   `LPBE_ASSERT(a_emul_release, clock, reset,
      fire && emit_v && mode_ff == lpbe_pkg::MODE_EMULATING |->
      (!emit_pr && emit_btn == cfg.target_button), "bad event while emulating")
   // A tick that fires the timeout moves the hold into emulation
   `LPBE_ASSERT(a_timeout_step, clock, reset,
      fire && op == lpbe_pkg::OP_TICK && mode_ff == lpbe_pkg::MODE_PENDING && emit_v |=>
      mode_ff == lpbe_pkg::MODE_EMULATING, "timeout did not enter emulation")

endmodule

`default_nettype wire

### design/lpbe_out_reg.sv
`default_nettype none

module lpbe_out_reg #(
   parameter int DATA_W = 48
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              fire,
   input  wire logic [DATA_W-1:0] res_data,
   input  wire logic              rsp_tready,
   output logic                   rsp_tvalid,
   output logic [DATA_W-1:0]      rsp_tdata,
   output logic                   space
);

   logic              valid_ff;
   logic              valid_in;
   logic [DATA_W-1:0] data_ff;

   // Room for a new result when empty or being drained
   assign space    = ~valid_ff | rsp_tready;
   assign valid_in = fire | (valid_ff & ~rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         data_ff <= res_data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire
